@@ hw/rtl/crtc_pkg.sv @@
// shared constants and types for the two-moduli crt combine unit
`timescale 1ns / 1ps
`default_nettype none
package crtc_pkg;

  // default modulus width
  localparam int unsigned ModWidth = 32;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NOT_INV = 2'd1,
    STATUS_RANGE   = 2'd2
  } crtc_status_e;

  // sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED_A,
    ST_INV,
    ST_RED_RB,
    ST_RED_RA,
    ST_SUB,
    ST_MMUL,
    ST_WMUL,
    ST_FIN
  } crtc_state_e;

endpackage
`default_nettype wire

@@ hw/rtl/crtc_modred.sv @@
// bit-serial reduction of a word modulo a modulus, one dividend bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module crtc_modred #(
  parameter int unsigned W = crtc_pkg::ModWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] num_i,
  input  wire logic [W-1:0] mod_i,
  output logic              done_o,
  output logic [W-1:0]      rem_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    sh_q;
  logic [W-1:0]    mod_q;
  logic [W-1:0]    rem_q;
  logic [W:0]      trial;
  logic [W:0]      rem_d;

  // shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial = {rem_q, sh_q[W-1]};
    if (trial >= {1'b0, mod_q}) begin
      rem_d = trial - {1'b0, mod_q};
    end else begin
      rem_d = trial;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= num_i;
      mod_q <= mod_i;
      rem_q <= '0;
    end else if (busy_q) begin
      sh_q  <= {sh_q[W-2:0], 1'b0};
      rem_q <= rem_d[W-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

@@ hw/rtl/crtc_inv.sv @@
// extended euclid inverse, each quotient built one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module crtc_inv #(
  parameter int unsigned W = crtc_pkg::ModWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] m_i,
  output logic              done_o,
  output logic              ok_o,
  output logic [W-1:0]      inv_o
);

  localparam int unsigned CntW = $clog2(W);
  localparam int unsigned TW   = W + 2;
  localparam int unsigned AW   = 2 * W + 2;

  logic            busy_q;
  logic            div_q;
  logic            done_q;
  logic            ok_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    m_q;
  logic [W-1:0]    r0_q;
  logic [W-1:0]    r1_q;
  logic [TW-1:0]   t0_q;
  logic [TW-1:0]   t1_q;
  logic [2*W-1:0]  rs_q;
  logic [AW-1:0]   ts_q;
  logic [W-1:0]    ra_q;
  logic [AW-1:0]   ta_q;
  logic [W-1:0]    inv_q;
  logic            fits;
  logic [W-1:0]    ra_d;
  logic [AW-1:0]   ta_d;
  logic [TW-1:0]   tpos;
  logic [TW-1:0]   tred;

  // one restoring step of r0 / r1, with t0 - q*t1 tracked alongside
  always_comb begin
    fits = rs_q <= {{W{1'b0}}, ra_q};
    ra_d = fits ? (ra_q - rs_q[W-1:0]) : ra_q;
    ta_d = fits ? (ta_q - ts_q) : ta_q;
  end

  // bring the final coefficient into 0..m-1
  always_comb begin
    tpos = t0_q[TW-1] ? (t0_q + {2'b00, m_q}) : t0_q;
    tred = (tpos >= {2'b00, m_q}) ? (tpos - {2'b00, m_q}) : tpos;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      div_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        div_q  <= 1'b0;
      end else if (busy_q && !div_q) begin
        if (r1_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          div_q <= 1'b1;
          cnt_q <= CntW'(W - 1);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          div_q <= 1'b0;
        end
      end
    end
  end

  // remainder and coefficient sequence
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      m_q  <= m_i;
      r0_q <= a_i;
      r1_q <= m_i;
      t0_q <= TW'(1);
      t1_q <= '0;
    end else if (busy_q && !div_q) begin
      ra_q  <= r0_q;
      ta_q  <= {{W{t0_q[TW-1]}}, t0_q};
      rs_q  <= {1'b0, r1_q, {(W - 1){1'b0}}};
      ts_q  <= AW'({{W{t1_q[TW-1]}}, t1_q} << (W - 1));
      ok_q  <= (r0_q == W'(1));
      inv_q <= tred[W-1:0];
    end else if (busy_q) begin
      ra_q <= ra_d;
      ta_q <= ta_d;
      rs_q <= {1'b0, rs_q[2*W-1:1]};
      ts_q <= {ts_q[AW-1], ts_q[AW-1:1]};
      if (cnt_q == '0) begin
        r0_q <= r1_q;
        r1_q <= ra_d;
        t0_q <= t1_q;
        t1_q <= ta_d[TW-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign ok_o   = ok_q;
  assign inv_o  = inv_q;

endmodule
`default_nettype wire

@@ hw/rtl/crtc_modmul.sv @@
// interleaved modular multiply, one multiplier bit per cycle msb first
`timescale 1ns / 1ps
`default_nettype none
module crtc_modmul #(
  parameter int unsigned W = crtc_pkg::ModWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] b_i,
  input  wire logic [W-1:0] m_i,
  output logic              done_o,
  output logic [W-1:0]      prod_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    a_q;
  logic [W-1:0]    b_q;
  logic [W-1:0]    m_q;
  logic [W-1:0]    acc_q;
  logic [W:0]      dbl;
  logic [W:0]      dbl_r;
  logic [W:0]      sum;
  logic [W:0]      sum_r;

  // acc = 2*acc + bit*b, reduced after each add
  always_comb begin
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= {1'b0, m_q}) ? (dbl - {1'b0, m_q}) : dbl;
    sum   = dbl_r + (a_q[W-1] ? {1'b0, b_q} : '0);
    sum_r = (sum >= {1'b0, m_q}) ? (sum - {1'b0, m_q}) : sum;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      a_q   <= {a_q[W-2:0], 1'b0};
      acc_q <= sum_r[W-1:0];
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire

@@ hw/rtl/crtc_wmul.sv @@
// two shift-add products sharing one multiplicand, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module crtc_wmul #(
  parameter int unsigned W = crtc_pkg::ModWidth
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [W-1:0] a_i,
  input  wire logic [W-1:0] x_i,
  input  wire logic [W-1:0] y_i,
  output logic              done_o,
  output logic [2*W-1:0]    px_o,
  output logic [2*W-1:0]    py_o
);

  localparam int unsigned CntW = $clog2(W);

  logic            busy_q;
  logic            done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    a_q;
  logic [W-1:0]    x_q;
  logic [W-1:0]    y_q;
  logic [2*W-1:0]  px_q;
  logic [2*W-1:0]  py_q;
  logic [2*W-1:0]  a_ext;

  assign a_ext = {{W{1'b0}}, a_q};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // accumulate msb first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      x_q  <= x_i;
      y_q  <= y_i;
      px_q <= '0;
      py_q <= '0;
    end else if (busy_q) begin
      x_q  <= {x_q[W-2:0], 1'b0};
      y_q  <= {y_q[W-2:0], 1'b0};
      px_q <= {px_q[2*W-2:0], 1'b0} + (x_q[W-1] ? a_ext : '0);
      py_q <= {py_q[2*W-2:0], 1'b0} + (y_q[W-1] ? a_ext : '0);
    end
  end

  assign done_o = done_q;
  assign px_o   = px_q;
  assign py_o   = py_q;

endmodule
`default_nettype wire

@@ hw/rtl/crt_two_moduli_combine_unit.sv @@
// top level: two-moduli crt combine in garner form with bit-serial units
// run time grows with the euclid steps of the inverse, at most about 1.44*W + 1
//   steps; a modulus b of 0 or 1 skips the units and goes straight to the finish state
// throughput: one beat at a time, the input ready again in the cycle after the result
//   is registered; the euclid inverse unit sets the pace
// reset: asynchronous active low, clears the sequencer and the output valid
`timescale 1ns / 1ps
`default_nettype none
module crt_two_moduli_combine_unit #(
  parameter int unsigned MOD_WIDTH = crtc_pkg::ModWidth
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // residue_a, modulus_a, residue_b, modulus_b, symmetric, zero pad
  input  wire logic [((4*MOD_WIDTH+2+7)/8)*8-1:0] s_axis_tdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // result_magnitude, result_negative, status, zero pad
  output logic [((2*MOD_WIDTH+3+7)/8)*8-1:0] m_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready
);

  localparam int unsigned W    = MOD_WIDTH;
  localparam int unsigned OutW = ((2 * W + 3 + 7) / 8) * 8;

  crtc_pkg::crtc_state_e  state_q, state_d;
  crtc_pkg::crtc_status_e status_q;

  logic [W-1:0]   ma_q, rb_q, mb_q, c_q, rbm_q, ram_q, s_sub, ra;
  logic [W:0]     amag_q;
  logic           aneg_q, sym_q;
  logic [2*W-1:0] x_q, mm_q, diff;
  logic [W:0]     in_ra, in_amag, sub_t;
  logic [W-1:0]   in_ma, in_rb, in_mb;
  logic           in_sym, in_fire, out_free;
  logic           out_valid_q, out_neg_q;
  logic [2*W-1:0] out_mag_q;
  crtc_pkg::crtc_status_e out_status_q;

  logic           red_start, inv_start, mm_start, wm_start;
  logic [W-1:0]   red_num, red_mod;
  logic           red_done, inv_done, inv_ok, mm_done, wm_done;
  logic [W-1:0]   red_rem, inv_val, mm_prod;
  logic [2*W-1:0] wm_px, wm_py;

  // input unpack
  assign in_ra   = s_axis_tdata[W:0];
  assign in_ma   = s_axis_tdata[2*W:W+1];
  assign in_rb   = s_axis_tdata[3*W:2*W+1];
  assign in_mb   = s_axis_tdata[4*W:3*W+1];
  assign in_sym  = s_axis_tdata[4*W+1];
  assign in_amag = in_ra[W] ? ((W+1)'(0) - in_ra) : in_ra;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;

  // residue a raised into 0..ma-1
  assign ra = aneg_q ? (ma_q - amag_q[W-1:0]) : amag_q[W-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      crtc_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = (in_mb <= W'(1)) ? crtc_pkg::ST_FIN : crtc_pkg::ST_RED_A;
        end
      end
      crtc_pkg::ST_RED_A: begin
        if (red_done) state_d = crtc_pkg::ST_INV;
      end
      crtc_pkg::ST_INV: begin
        if (inv_done) begin
          if (!inv_ok || (amag_q >= {1'b0, ma_q})) begin
            state_d = crtc_pkg::ST_FIN;
          end else begin
            state_d = crtc_pkg::ST_RED_RB;
          end
        end
      end
      crtc_pkg::ST_RED_RB: begin
        if (red_done) state_d = crtc_pkg::ST_RED_RA;
      end
      crtc_pkg::ST_RED_RA: begin
        if (red_done) state_d = crtc_pkg::ST_SUB;
      end
      crtc_pkg::ST_SUB:  state_d = crtc_pkg::ST_MMUL;
      crtc_pkg::ST_MMUL: begin
        if (mm_done) state_d = crtc_pkg::ST_WMUL;
      end
      crtc_pkg::ST_WMUL: begin
        if (wm_done) state_d = crtc_pkg::ST_FIN;
      end
      crtc_pkg::ST_FIN: begin
        if (out_free) state_d = crtc_pkg::ST_IDLE;
      end
      default: state_d = crtc_pkg::ST_IDLE;
    endcase
  end

  // unit launches on state entry, first reduction fed straight from the beat
  always_comb begin
    s_axis_tready = (state_q == crtc_pkg::ST_IDLE);
    red_start = (state_d != state_q) && ((state_d == crtc_pkg::ST_RED_A) ||
                (state_d == crtc_pkg::ST_RED_RB) || (state_d == crtc_pkg::ST_RED_RA));
    inv_start = (state_d != state_q) && (state_d == crtc_pkg::ST_INV);
    mm_start  = (state_d != state_q) && (state_d == crtc_pkg::ST_MMUL);
    wm_start  = (state_d != state_q) && (state_d == crtc_pkg::ST_WMUL);
    red_mod   = (state_q == crtc_pkg::ST_IDLE) ? in_mb : mb_q;
    unique case (state_d)
      crtc_pkg::ST_RED_A:  red_num = in_ma;
      crtc_pkg::ST_RED_RB: red_num = rb_q;
      default:             red_num = ra;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crtc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // symmetric fold difference, and the wrapped term of the garner difference
  assign diff  = mm_q - x_q;
  assign sub_t = {1'b0, rbm_q} + {1'b0, mb_q} - {1'b0, ram_q};

  // garner difference (rb - ra) mod mb
  assign s_sub = (rbm_q >= ram_q) ? (rbm_q - ram_q) : sub_t[W-1:0];

  // working registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ma_q     <= in_ma;
      rb_q     <= in_rb;
      mb_q     <= in_mb;
      amag_q   <= in_amag;
      aneg_q   <= in_ra[W];
      sym_q    <= in_sym;
      status_q <= (in_mb <= W'(1)) ? crtc_pkg::STATUS_NOT_INV : crtc_pkg::STATUS_OK;
    end
    if ((state_q == crtc_pkg::ST_INV) && inv_done) begin
      c_q <= inv_val;
      if (!inv_ok) begin
        status_q <= crtc_pkg::STATUS_NOT_INV;
      end else if (amag_q >= {1'b0, ma_q}) begin
        status_q <= crtc_pkg::STATUS_RANGE;
      end
    end
    if ((state_q == crtc_pkg::ST_RED_RB) && red_done) rbm_q <= red_rem;
    if ((state_q == crtc_pkg::ST_RED_RA) && red_done) ram_q <= red_rem;
    if ((state_q == crtc_pkg::ST_WMUL) && wm_done) begin
      x_q  <= wm_px + {{W{1'b0}}, ra};
      mm_q <= wm_py;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == crtc_pkg::ST_FIN) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == crtc_pkg::ST_FIN) && out_free) begin
      out_status_q <= status_q;
      if (status_q != crtc_pkg::STATUS_OK) begin
        out_mag_q <= '0;
        out_neg_q <= 1'b0;
      end else if (sym_q && (diff < x_q)) begin
        out_mag_q <= diff;
        out_neg_q <= 1'b1;
      end else begin
        out_mag_q <= x_q;
        out_neg_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutW'({out_status_q, out_neg_q, out_mag_q});

  crtc_modred #(.W(W)) u_red (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (red_start),
    .num_i   (red_num),
    .mod_i   (red_mod),
    .done_o  (red_done),
    .rem_o   (red_rem)
  );

  crtc_inv #(.W(W)) u_inv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (inv_start),
    .a_i     (red_rem),
    .m_i     (mb_q),
    .done_o  (inv_done),
    .ok_o    (inv_ok),
    .inv_o   (inv_val)
  );

  crtc_modmul #(.W(W)) u_mm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (s_sub),
    .b_i     (c_q),
    .m_i     (mb_q),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  crtc_wmul #(.W(W)) u_wm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wm_start),
    .a_i     (ma_q),
    .x_i     (mm_prod),
    .y_i     (mb_q),
    .done_o  (wm_done),
    .px_o    (wm_px),
    .py_o    (wm_py)
  );

  // no second beat taken right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // a negative result only comes with ok status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_neg_q) |-> (out_status_q == crtc_pkg::STATUS_OK))
    else $error("negative result with error status");

  // error results carry zero magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (out_status_q != crtc_pkg::STATUS_OK)) |-> (out_mag_q == '0))
    else $error("error result with nonzero magnitude");

  // reducer finishes only in a reduction state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_done |-> ((state_q == crtc_pkg::ST_RED_A) || (state_q == crtc_pkg::ST_RED_RB) ||
                  (state_q == crtc_pkg::ST_RED_RA)))
    else $error("stray reducer completion");

endmodule
`default_nettype wire
